// File: src/sqvb_pkg.sv
// ----------------------------------------------------------------------------
// sqvb_pkg
// Shared types and constants of the sprite quad vertex batcher.
// ----------------------------------------------------------------------------
package sqvb_pkg;

    typedef enum logic [1:0] {
        ACT_DRAW  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_END   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [63:0] One    = 64'h4000_0000;
    localparam logic [63:0] HalfPi = 64'd1686629713;
    localparam logic [15:0] TilingOne = 16'h0100;

    typedef struct packed {
        logic               is_flush;
        logic               last;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [15:0]        rotation;
        logic [31:0]        color;
        logic [15:0]        tiling;
        logic [4:0]         slot;
        logic [16:0]        batch_indices;
        logic [5:0]         batch_slots;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: src/sqvb_ram.sv
// ----------------------------------------------------------------------------
// sqvb_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module sqvb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/sqvb_queue.sv
// ----------------------------------------------------------------------------
// sqvb_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sqvb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sqvb_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sqvb_pkg::t_job o_data
);
    import sqvb_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= !r_wp;
            if (pop_ok) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end
endmodule

// File: src/sqvb_front.sv
// ----------------------------------------------------------------------------
// sqvb_front
// Accept items, keep batch counts, look up texture slots, queue jobs.
// ----------------------------------------------------------------------------
module sqvb_front #(
    parameter int MAX_QUADS     = 16384,
    parameter int TEXTURE_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_size_x,
    input  logic signed [31:0] i_size_y,
    input  logic [15:0]        i_rotation,
    input  logic               i_textured,
    input  logic [15:0]        i_texture_id,
    input  logic [15:0]        i_tiling,
    input  logic [31:0]        i_color,
    output logic               o_push,
    output sqvb_pkg::t_job     o_job,
    input  logic               i_full
);
    import sqvb_pkg::*;

    localparam int IdxW = $clog2(MAX_QUADS * 6 + 1);
    localparam int SW   = $clog2(TEXTURE_SLOTS + 1);
    localparam int AW   = $clog2(TEXTURE_SLOTS);
    localparam logic [IdxW-1:0] IdxLimit = IdxW'(MAX_QUADS * 6);
    localparam logic [SW-1:0]   SlotsMax = SW'(TEXTURE_SLOTS);

    typedef enum logic [7:0] {
        F_IDLE       = 8'b0000_0001,
        F_FLUSH_IDX  = 8'b0000_0010,
        F_FLUSH_END  = 8'b0000_0100,
        F_RD         = 8'b0000_1000,
        F_CMP        = 8'b0001_0000,
        F_FLUSH_SLOT = 8'b0010_0000,
        F_ALLOC      = 8'b0100_0000,
        F_QUAD       = 8'b1000_0000
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [IdxW-1:0]    r_idx, n_idx;
    logic [SW-1:0]      r_slots, n_slots;
    logic [SW-1:0]      r_scan, n_scan;
    logic [SW-1:0]      r_slot, n_slot;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z, r_size_x, r_size_y;
    logic [15:0]        r_rotation, r_tid, r_tiling;
    logic               r_textured;
    logic [31:0]        r_color;
    logic               accept;
    logic               ram_we;
    logic [15:0]        ram_rdata;
    logic [IdxW+16:0]   idx_ext;
    logic [SW+5:0]      slots_ext;
    logic [SW+4:0]      slot_ext;

    assign o_stall = (r_state != F_IDLE);
    assign accept  = i_valid && !o_stall;
    assign ram_we  = (r_state == F_ALLOC);

    sqvb_ram #(.WIDTH(16), .DEPTH(TEXTURE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slots[AW-1:0]),
        .i_wdata (r_tid),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos_x    <= i_pos_x;
            r_pos_y    <= i_pos_y;
            r_pos_z    <= i_pos_z;
            r_size_x   <= i_size_x;
            r_size_y   <= i_size_y;
            r_rotation <= i_rotation;
            r_textured <= i_textured;
            r_tid      <= i_texture_id;
            r_tiling   <= i_tiling;
            r_color    <= i_color;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_slots = r_slots;
        n_scan  = r_scan;
        n_slot  = r_slot;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_scan = SW'(1);
                    n_slot = '0;
                    unique case (t_action'(i_action))
                        ACT_BEGIN: begin
                            n_idx   = '0;
                            n_slots = SW'(1);
                        end
                        ACT_END: n_state = F_FLUSH_END;
                        ACT_DRAW: begin
                            priority if (r_idx >= IdxLimit) n_state = F_FLUSH_IDX;
                            else if (i_textured) n_state = F_RD;
                            else n_state = F_QUAD;
                        end
                        default: n_state = F_IDLE;
                    endcase
                end
            end
            F_FLUSH_END: begin
                o_push = !i_full;
                if (!i_full) n_state = F_IDLE;
            end
            F_FLUSH_IDX: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_idx   = '0;
                    n_slots = SW'(1);
                    n_state = r_textured ? F_RD : F_QUAD;
                end
            end
            F_RD: begin
                priority if (r_scan < r_slots) n_state = F_CMP;
                else if (r_slots >= SlotsMax) n_state = F_FLUSH_SLOT;
                else n_state = F_ALLOC;
            end
            F_CMP: begin
                if (ram_rdata == r_tid) begin
                    n_slot  = r_scan;
                    n_state = F_QUAD;
                end else begin
                    n_scan  = r_scan + SW'(1);
                    n_state = F_RD;
                end
            end
            F_FLUSH_SLOT: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_idx   = '0;
                    n_slots = SW'(1);
                    n_state = F_ALLOC;
                end
            end
            F_ALLOC: begin
                n_slot  = r_slots;
                n_slots = r_slots + SW'(1);
                n_state = F_QUAD;
            end
            F_QUAD: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_idx   = r_idx + IdxW'(6);
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_idx   <= '0;
            r_slots <= SW'(1);
            r_scan  <= SW'(1);
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_slots <= n_slots;
            r_scan  <= n_scan;
            r_slot  <= n_slot;
        end
    end

    assign idx_ext   = {17'd0, r_idx};
    assign slots_ext = {6'd0, r_slots};
    assign slot_ext  = {5'd0, r_slot};

    always_comb begin
        o_job.is_flush      = (r_state != F_QUAD);
        o_job.last          = (r_state == F_QUAD) || (r_state == F_FLUSH_END);
        o_job.pos_x         = r_pos_x;
        o_job.pos_y         = r_pos_y;
        o_job.pos_z         = r_pos_z;
        o_job.size_x        = r_size_x;
        o_job.size_y        = r_size_y;
        o_job.rotation      = r_rotation;
        o_job.color         = r_textured ? 32'hFFFF_FFFF : r_color;
        o_job.tiling        = r_textured ? r_tiling : TilingOne;
        o_job.slot          = slot_ext[4:0];
        o_job.batch_indices = idx_ext[16:0];
        o_job.batch_slots   = slots_ext[5:0];
    end
endmodule

// File: src/sqvb_back.sv
// ----------------------------------------------------------------------------
// sqvb_back
// Carry out queued jobs: trig lookup, corner transform, result register.
// ----------------------------------------------------------------------------
module sqvb_back #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  sqvb_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic signed [31:0] o_vtx_x,
    output logic signed [31:0] o_vtx_y,
    output logic signed [31:0] o_vtx_z,
    output logic               o_tex_u,
    output logic               o_tex_v,
    output logic [31:0]        o_vtx_color,
    output logic [4:0]         o_tex_slot,
    output logic [15:0]        o_vtx_tiling,
    output logic [16:0]        o_batch_indices,
    output logic [5:0]         o_batch_slots,
    output logic               o_last
);
    import sqvb_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH);

    typedef logic [35:0] t_rom [SINE_TABLE_DEPTH];

    function automatic logic [35:0] trig_entry(input logic [63:0] kk);
        logic [63:0]        t, r, x, x2, a, b, s, c, tmp;
        logic [1:0]         q;
        logic               sw;
        logic signed [17:0] so, co;
        t  = (kk << 32) / SINE_TABLE_DEPTH;
        q  = t[31:30];
        r  = {34'd0, t[29:0]};
        sw = (r > 64'h2000_0000);
        if (sw) r = One - r;
        x  = (r * HalfPi) >> 30;
        x2 = (x * x) >> 30;
        a  = One - x2 / 42;
        a  = One - ((x2 * a) >> 30) / 20;
        a  = One - ((x2 * a) >> 30) / 6;
        a  = (x * a) >> 30;
        b  = One - x2 / 56;
        b  = One - ((x2 * b) >> 30) / 30;
        b  = One - ((x2 * b) >> 30) / 12;
        b  = One - ((x2 * b) >> 30) / 2;
        s  = (a + 64'd8192) >> 14;
        c  = (b + 64'd8192) >> 14;
        if (sw) begin
            tmp = s;
            s   = c;
            c   = tmp;
        end
        unique case (q)
            2'd0: begin so = 18'(s);  co = 18'(c);  end
            2'd1: begin so = 18'(c);  co = -18'(s); end
            2'd2: begin so = -18'(s); co = -18'(c); end
            default: begin so = -18'(c); co = 18'(s); end
        endcase
        return {so, co};
    endfunction

    function automatic t_rom build_rom();
        t_rom m;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            m[k] = trig_entry(64'(k));
        end
        return m;
    endfunction

    localparam t_rom RomTable = build_rom();

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_FLUSH = 5'b00010,
        B_ROM   = 5'b00100,
        B_MUL   = 5'b01000,
        B_VTX   = 5'b10000
    } t_bstate;

    t_bstate            r_state;
    t_job               r_job;
    logic [35:0]        r_sc;
    logic signed [49:0] r_pcx, r_psy, r_psx, r_pcy;
    logic [1:0]         r_corner;
    logic [47:0]        rom_prod;
    logic [AW-1:0]      rom_idx;
    logic signed [17:0] sn, cs;
    logic               cu, cv;
    logic signed [51:0] tcx, tsy, tsx, tcy, dsum, esum;
    logic signed [34:0] dd, ee;
    logic signed [36:0] xs, ys;
    logic               out_free;

    assign rom_prod = 48'(r_job.rotation) * 48'(SINE_TABLE_DEPTH);
    assign rom_idx  = rom_prod[16 +: AW];
    assign sn       = $signed(r_sc[35:18]);
    assign cs       = $signed(r_sc[17:0]);
    assign cu       = r_corner[0] ^ r_corner[1];
    assign cv       = r_corner[1];
    assign tcx      = cu ? 52'(r_pcx) : -52'(r_pcx);
    assign tsx      = cu ? 52'(r_psx) : -52'(r_psx);
    assign tsy      = cv ? 52'(r_psy) : -52'(r_psy);
    assign tcy      = cv ? 52'(r_pcy) : -52'(r_pcy);
    assign dsum     = tcx - tsy + 52'sd65536;
    assign esum     = tsx + tcy + 52'sd65536;
    assign dd       = 35'(dsum >>> 17);
    assign ee       = 35'(esum >>> 17);
    assign xs       = 37'(r_job.pos_x) + 37'(dd);
    assign ys       = 37'(r_job.pos_y) + 37'(ee);
    assign out_free = !o_valid || !i_stall;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_state == B_ROM) r_sc <= RomTable[rom_idx];
        if (r_state == B_MUL) begin
            r_pcx <= cs * r_job.size_x;
            r_psy <= sn * r_job.size_y;
            r_psx <= sn * r_job.size_x;
            r_pcy <= cs * r_job.size_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            o_kind          <= 1'b0;
            o_vtx_x         <= '0;
            o_vtx_y         <= '0;
            o_vtx_z         <= '0;
            o_tex_u         <= 1'b0;
            o_tex_v         <= 1'b0;
            o_vtx_color     <= '0;
            o_tex_slot      <= '0;
            o_vtx_tiling    <= '0;
            o_batch_indices <= '0;
            o_batch_slots   <= '0;
            o_last          <= 1'b0;
            if (r_state == B_FLUSH) begin
                o_kind          <= 1'b1;
                o_batch_indices <= r_job.batch_indices;
                o_batch_slots   <= r_job.batch_slots;
                o_last          <= r_job.last;
            end else if (r_state == B_VTX) begin
                o_vtx_x      <= sat32(xs);
                o_vtx_y      <= sat32(ys);
                o_vtx_z      <= r_job.pos_z;
                o_tex_u      <= cu;
                o_tex_v      <= cv;
                o_vtx_color  <= r_job.color;
                o_tex_slot   <= r_job.slot;
                o_vtx_tiling <= r_job.tiling;
                o_last       <= (r_corner == 2'd3);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_corner <= 2'd0;
            o_valid  <= 1'b0;
        end else begin
            if (out_free) begin
                o_valid <= (r_state == B_FLUSH) || (r_state == B_VTX);
            end
            unique case (r_state)
                B_IDLE: begin
                    r_corner <= 2'd0;
                    if (o_pop) r_state <= i_job.is_flush ? B_FLUSH : B_ROM;
                end
                B_FLUSH: if (out_free) r_state <= B_IDLE;
                B_ROM: r_state <= B_MUL;
                B_MUL: r_state <= B_VTX;
                B_VTX: begin
                    if (out_free) begin
                        r_corner <= r_corner + 2'd1;
                        if (r_corner == 2'd3) r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// File: src/sprite_quad_vertex_batcher.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_batcher
// Turns draw-quad requests into four transformed vertices with batch flushes.
// ----------------------------------------------------------------------------
// The front part queues jobs in a two-entry queue, so it can take a new item
// while the back part works on earlier jobs, as long as the queue has room.
// The back part emits a flush marker, or does trig ROM read, multiply and one
// vertex per cycle unless stalled; a textured quad adds F_RD, F_CMP per slot.
// Reset: synchronous, active low; empties the batch (slot count one).
// ----------------------------------------------------------------------------
module sprite_quad_vertex_batcher #(
    parameter int MAX_QUADS        = 16384,
    parameter int TEXTURE_SLOTS    = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_size_x,
    input  logic signed [31:0] i_size_y,
    input  logic [15:0]        i_rotation,
    input  logic               i_textured,
    input  logic [15:0]        i_texture_id,
    input  logic [15:0]        i_tiling,
    input  logic [31:0]        i_color,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic signed [31:0] o_vtx_x,
    output logic signed [31:0] o_vtx_y,
    output logic signed [31:0] o_vtx_z,
    output logic               o_tex_u,
    output logic               o_tex_v,
    output logic [31:0]        o_vtx_color,
    output logic [4:0]         o_tex_slot,
    output logic [15:0]        o_vtx_tiling,
    output logic [16:0]        o_batch_indices,
    output logic [5:0]         o_batch_slots,
    output logic               o_last
);
    import sqvb_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_job push_job, pop_job;

    sqvb_front #(
        .MAX_QUADS     (MAX_QUADS),
        .TEXTURE_SLOTS (TEXTURE_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_size_x     (i_size_x),
        .i_size_y     (i_size_y),
        .i_rotation   (i_rotation),
        .i_textured   (i_textured),
        .i_texture_id (i_texture_id),
        .i_tiling     (i_tiling),
        .i_color      (i_color),
        .o_push       (q_push),
        .o_job        (push_job),
        .i_full       (q_full)
    );

    sqvb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (pop_job)
    );

    sqvb_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_job           (pop_job),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_vtx_x         (o_vtx_x),
        .o_vtx_y         (o_vtx_y),
        .o_vtx_z         (o_vtx_z),
        .o_tex_u         (o_tex_u),
        .o_tex_v         (o_tex_v),
        .o_vtx_color     (o_vtx_color),
        .o_tex_slot      (o_tex_slot),
        .o_vtx_tiling    (o_vtx_tiling),
        .o_batch_indices (o_batch_indices),
        .o_batch_slots   (o_batch_slots),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_tex_slot == 5'd0 && o_vtx_color == 32'd0 && !o_tex_u)
        else $error("flush marker carries vertex data");

    a_flat_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind && o_vtx_color != 32'hFFFF_FFFF
        |-> o_tex_slot == 5'd0 && o_vtx_tiling == TilingOne)
        else $error("flat quad vertex with texture slot or tiling");
`endif
endmodule
